// ===== hdl/aps_pkg.sv =====
// Shared types and constants for the actuator pin sequencer.
package aps_pkg;

  // Field widths fixed by the interface
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int FUNC_W      = 3;
  localparam int PHASE_W     = 5;
  localparam int DISP_W      = 16;

  // Timeout used when a timeout register holds zero
  localparam logic [CFG_DATA_W-1:0] DEFAULT_TIMEOUT = 16'd500;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PIN_ENABLED      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_DELAY    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKWARD_DELAY   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_TIMEOUT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKWARD_TIMEOUT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_CHECK    = 3'd5;

  // Command codes carried by func
  localparam logic [FUNC_W-1:0] FN_NONE     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_GO_FWD   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GO_BWD   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_HOLD_FWD = 3'd3;
  localparam logic [FUNC_W-1:0] FN_HOLD_BWD = 3'd4;
  localparam logic [FUNC_W-1:0] FN_STOP     = 3'd5;
  localparam logic [FUNC_W-1:0] FN_ABORT    = 3'd6;
  localparam logic [FUNC_W-1:0] FN_IDLE     = 3'd7;

  // Sequence phases
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 5'd0,
    PH_FSTART  = 5'd1,
    PH_FDELAY  = 5'd2,
    PH_FARM    = 5'd3,
    PH_FMOVE   = 5'd4,
    PH_FREACH  = 5'd5,
    PH_FSKIP   = 5'd6,
    PH_FDONE   = 5'd7,
    PH_FHOLD   = 5'd8,
    PH_BSTART  = 5'd9,
    PH_BDELAY  = 5'd10,
    PH_BARM    = 5'd11,
    PH_BMOVE   = 5'd12,
    PH_BREACH  = 5'd13,
    PH_BSKIP   = 5'd14,
    PH_BDONE   = 5'd15,
    PH_BHOLD   = 5'd16,
    PH_STOP    = 5'd17,
    PH_ABORT   = 5'd18,
    PH_ALARM   = 5'd19,
    PH_ALRESET = 5'd20
  } phase_t;

  // One result transaction
  typedef struct packed {
    logic               valve_forward;
    logic               moving_forward_info;
    logic [PHASE_W-1:0] phase_code;
    logic [DISP_W-1:0]  shown_delay;
    logic               alarm_not_forward;
    logic               alarm_not_backward;
    logic               alarm_carriage;
  } res_t;

endpackage

// ===== hdl/actuator_pin_sequencer.sv =====
// Top level of the actuator pin sequencer: phase logic, timers and output buffer.
// A result is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one transaction per cycle while in_stall is low; the phase/timer update is one combinational pass.
// A two-entry output buffer (output register plus skid register) lets a new transaction
// be accepted while a finished result is stalled; in_stall rises only when both are full.
// Reset (rst_n low, synchronous): idle phase, timers cleared, registers at default values.
module actuator_pin_sequencer
  import aps_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic                   in_at_forward_limit,
  input  logic                   in_at_backward_limit,
  input  logic                   in_carriage_at_back,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_valve_forward,
  output logic                   out_moving_forward_info,
  output logic [PHASE_W-1:0]     out_phase_code,
  output logic [DISP_W-1:0]      out_shown_delay,
  output logic                   out_alarm_not_forward,
  output logic                   out_alarm_not_backward,
  output logic                   out_alarm_carriage
);

  localparam logic [32:0] TMAX_EXT = (33'd1 << TIMER_BITS) - 33'd1;

  typedef logic [TIMER_BITS-1:0] tcnt_t;

  // Preset from a 16-bit register value, clamped to the largest count
  function automatic tcnt_t clamp_preset(input logic [CFG_DATA_W-1:0] v);
    logic [32:0] ext;
    ext = 33'(v);
    if (ext > TMAX_EXT) return TMAX_EXT[TIMER_BITS-1:0];
    else return ext[TIMER_BITS-1:0];
  endfunction

  function automatic tcnt_t timeout_preset(input logic [CFG_DATA_W-1:0] v);
    return clamp_preset((v == '0) ? DEFAULT_TIMEOUT : v);
  endfunction

  // Configuration registers
  logic                  pin_enabled_r;
  logic [CFG_DATA_W-1:0] forward_delay_r;
  logic [CFG_DATA_W-1:0] backward_delay_r;
  logic [CFG_DATA_W-1:0] forward_timeout_r;
  logic [CFG_DATA_W-1:0] backward_timeout_r;
  logic                  timeout_check_r;

  // Sequence state
  phase_t            phase_r, phase_nxt;
  logic              valve_r, valve_nxt;
  logic              info_r, info_nxt;
  logic              delay_run_r, delay_run_nxt;
  tcnt_t             delay_count_r, delay_count_nxt;
  tcnt_t             delay_preset_r, delay_preset_nxt;
  logic              limit_run_r, limit_run_nxt;
  tcnt_t             limit_count_r, limit_count_nxt;
  tcnt_t             limit_preset_r, limit_preset_nxt;
  logic [DISP_W-1:0] display_r, display_nxt;

  // Output buffer
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;
  res_t res_new;

  logic   accept, out_take;
  logic   delay_done, limit_done;
  logic   al_f, al_b, al_c;
  phase_t cmd_phase;
  logic [31:0] delay_count_ext;

  assign accept   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  assign delay_done      = delay_run_r && (delay_count_r >= delay_preset_r);
  assign limit_done      = limit_run_r && (limit_count_r >= limit_preset_r);
  assign delay_count_ext = 32'(delay_count_r);

  // Command decode
  always_comb begin
    case (in_func)
      FN_GO_FWD:   cmd_phase = PH_FSTART;
      FN_GO_BWD:   cmd_phase = PH_BSTART;
      FN_HOLD_FWD: cmd_phase = PH_FHOLD;
      FN_HOLD_BWD: cmd_phase = PH_BHOLD;
      FN_STOP:     cmd_phase = PH_STOP;
      FN_ABORT:    cmd_phase = PH_ABORT;
      FN_IDLE:     cmd_phase = PH_IDLE;
      default:     cmd_phase = phase_r;
    endcase
  end

  // Phase logic for one scan tick
  always_comb begin
    phase_nxt        = (in_func != FN_NONE) ? cmd_phase : phase_r;
    valve_nxt        = valve_r;
    info_nxt         = info_r;
    delay_run_nxt    = delay_run_r;
    delay_preset_nxt = delay_preset_r;
    limit_run_nxt    = limit_run_r;
    limit_preset_nxt = limit_preset_r;
    display_nxt      = display_r;
    al_f = 1'b0;
    al_b = 1'b0;
    al_c = 1'b0;

    case (phase_nxt)
      PH_IDLE, PH_STOP, PH_ABORT, PH_ALARM, PH_ALRESET: begin
        limit_run_nxt = 1'b0;
        delay_run_nxt = 1'b0;
        if (phase_nxt == PH_STOP || phase_nxt == PH_ABORT) phase_nxt = PH_IDLE;
        else if (phase_nxt == PH_ALRESET) phase_nxt = PH_ALARM;
      end
      PH_FSTART: begin
        if (pin_enabled_r && forward_delay_r != '0) begin
          delay_run_nxt    = 1'b1;
          delay_preset_nxt = clamp_preset(forward_delay_r);
          phase_nxt        = PH_FDELAY;
        end else begin
          phase_nxt = PH_FARM;
        end
      end
      PH_BSTART: begin
        if (pin_enabled_r && backward_delay_r != '0) begin
          delay_run_nxt    = 1'b1;
          delay_preset_nxt = clamp_preset(backward_delay_r);
          phase_nxt        = PH_BDELAY;
        end else begin
          phase_nxt = PH_BARM;
        end
      end
      PH_FDELAY, PH_BDELAY: begin
        display_nxt = delay_count_ext[DISP_W-1:0];
        if (delay_done) begin
          delay_run_nxt = 1'b0;
          phase_nxt     = (phase_nxt == PH_FDELAY) ? PH_FARM : PH_BARM;
        end
      end
      PH_FARM: begin
        if (pin_enabled_r) begin
          limit_run_nxt    = 1'b1;
          limit_preset_nxt = timeout_preset(forward_timeout_r);
          phase_nxt        = PH_FMOVE;
        end else begin
          phase_nxt = PH_FSKIP;
        end
      end
      PH_FMOVE: begin
        info_nxt  = 1'b1;
        valve_nxt = 1'b1;
        if (in_at_forward_limit) phase_nxt = PH_FREACH;
      end
      PH_FREACH, PH_BREACH: begin
        limit_run_nxt = 1'b0;
        delay_run_nxt = 1'b0;
        if (phase_nxt == PH_BREACH) info_nxt = 1'b0;
        phase_nxt = (phase_nxt == PH_FREACH) ? PH_FDONE : PH_BDONE;
      end
      PH_FSKIP, PH_BSKIP: begin
        info_nxt      = 1'b0;
        valve_nxt     = 1'b0;
        limit_run_nxt = 1'b0;
        delay_run_nxt = 1'b0;
        phase_nxt = (phase_nxt == PH_FSKIP) ? PH_FDONE : PH_BDONE;
      end
      PH_FHOLD: begin
        info_nxt  = 1'b1;
        valve_nxt = 1'b1;
      end
      PH_BARM: begin
        if (pin_enabled_r) begin
          limit_run_nxt    = 1'b1;
          limit_preset_nxt = timeout_preset(backward_timeout_r);
          phase_nxt        = PH_BMOVE;
        end else if (in_at_backward_limit) begin
          phase_nxt = PH_BSKIP;
        end else begin
          al_b      = 1'b1;
          phase_nxt = PH_ALARM;
        end
      end
      PH_BMOVE: begin
        info_nxt  = 1'b0;
        valve_nxt = 1'b0;
        if (in_at_backward_limit) phase_nxt = PH_BREACH;
      end
      PH_BHOLD: begin
        info_nxt  = 1'b0;
        valve_nxt = 1'b0;
      end
      default: ;
    endcase

    // Motion timeout
    if (limit_done && timeout_check_r) begin
      if (phase_nxt == PH_FMOVE) al_f = 1'b1;
      if (phase_nxt == PH_BMOVE) al_b = 1'b1;
      phase_nxt = PH_ALRESET;
    end

    // Carriage interlock on forward motion
    if (phase_nxt == PH_FMOVE && !in_carriage_at_back) begin
      al_c      = 1'b1;
      phase_nxt = PH_ALARM;
    end

    // On-delay timers count up to their preset while running
    if (!delay_run_nxt) delay_count_nxt = '0;
    else if (delay_count_r < delay_preset_nxt) delay_count_nxt = delay_count_r + 1'b1;
    else delay_count_nxt = delay_count_r;

    if (!limit_run_nxt) limit_count_nxt = '0;
    else if (limit_count_r < limit_preset_nxt) limit_count_nxt = limit_count_r + 1'b1;
    else limit_count_nxt = limit_count_r;

    res_new.valve_forward       = valve_nxt;
    res_new.moving_forward_info = info_nxt;
    res_new.phase_code          = phase_nxt;
    res_new.shown_delay         = display_nxt;
    res_new.alarm_not_forward   = al_f;
    res_new.alarm_not_backward  = al_b;
    res_new.alarm_carriage      = al_c;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_enabled_r      <= 1'b1;
      forward_delay_r    <= '0;
      backward_delay_r   <= '0;
      forward_timeout_r  <= DEFAULT_TIMEOUT;
      backward_timeout_r <= DEFAULT_TIMEOUT;
      timeout_check_r    <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_PIN_ENABLED:      pin_enabled_r      <= cfg_data[0];
        CFG_FORWARD_DELAY:    forward_delay_r    <= cfg_data;
        CFG_BACKWARD_DELAY:   backward_delay_r   <= cfg_data;
        CFG_FORWARD_TIMEOUT:  forward_timeout_r  <= cfg_data;
        CFG_BACKWARD_TIMEOUT: backward_timeout_r <= cfg_data;
        CFG_TIMEOUT_CHECK:    timeout_check_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequence state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      valve_r        <= 1'b0;
      info_r         <= 1'b0;
      delay_run_r    <= 1'b0;
      delay_count_r  <= '0;
      delay_preset_r <= '0;
      limit_run_r    <= 1'b0;
      limit_count_r  <= '0;
      limit_preset_r <= '0;
      display_r      <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      valve_r        <= valve_nxt;
      info_r         <= info_nxt;
      delay_run_r    <= delay_run_nxt;
      delay_count_r  <= delay_count_nxt;
      delay_preset_r <= delay_preset_nxt;
      limit_run_r    <= limit_run_nxt;
      limit_count_r  <= limit_count_nxt;
      limit_preset_r <= limit_preset_nxt;
      display_r      <= display_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_take) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_r <= skid_r;
    end else if (accept) begin
      if (!out_valid_r || out_take) out_r <= res_new;
      else skid_r <= res_new;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_valve_forward       = out_r.valve_forward;
  assign out_moving_forward_info = out_r.moving_forward_info;
  assign out_phase_code          = out_r.phase_code;
  assign out_shown_delay         = out_r.shown_delay;
  assign out_alarm_not_forward   = out_r.alarm_not_forward;
  assign out_alarm_not_backward  = out_r.alarm_not_backward;
  assign out_alarm_carriage      = out_r.alarm_carriage;

endmodule

// ===== hdl/aps_checker.sv =====
// Port-level checks for the actuator pin sequencer, bound to the top level.
module aps_props
  import aps_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PHASE_W-1:0] out_phase_code,
  input logic [DISP_W-1:0]  out_shown_delay,
  input logic               out_alarm_not_forward,
  input logic               out_alarm_not_backward,
  input logic               out_alarm_carriage
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_phase_code)
      && $stable(out_shown_delay))
    else $error("stalled result changed");

  // Carriage alarm always lands in the alarm phase; the valve may not be driven yet
  // when the interlock trips on the tick that arms the forward motion
  a_carriage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_carriage |-> out_phase_code == PH_ALARM)
    else $error("carriage alarm outside alarm phase");

  // Forward timeout leads to alarm reset
  a_fwd_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_not_forward |-> out_phase_code == PH_ALRESET)
    else $error("forward timeout in wrong phase");

  // At most one alarm per tick
  a_one_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_alarm_not_forward, out_alarm_not_backward,
      out_alarm_carriage}))
    else $error("more than one alarm raised");

  // Only defined phases are reported
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase_code <= PH_ALRESET)
    else $error("undefined phase code");

endmodule

bind actuator_pin_sequencer aps_props u_aps_props (.*);
